>>> rtl/core/lru_slot_mapper_core_defines.svh
// Assertion macros for the slot mapper checker
`ifndef LRU_SLOT_MAPPER_CORE_DEFINES_SVH
`define LRU_SLOT_MAPPER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lsm_pkg.sv
// Shared constants for the LRU slot mapper
package lsm_pkg;

  localparam int ID_W          = 9;
  localparam int NUM_SLOTS_W   = 10;
  localparam int AGE_W         = 64;
  localparam int NUM_ITEMS_DEF = 512;

  localparam logic [NUM_SLOTS_W-1:0] NUM_SLOTS_RST = 10'd192;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

endpackage

>>> rtl/core/lru_slot_mapper_core.sv
// LRU slot mapper: item-to-slot map with least-recently-used replacement
//
//  channel | dir | fields (low bit up)
//  in_     | in  | tdata: item_id
//  out_    | out | tdata: slot, evicted_id   tuser: hit, evict_valid
//  cfg_    | in  | wr_data: num_slots
//
// After reset a clearing pass writes every entry; in_tready stays low.
// A hit passes ST_LOOK, then ST_RESP raises out_tvalid; an out-of-range item
// goes straight to ST_RESP. A miss scans up to n slots, n the effective slot
// count (NUM_ITEMS when num_slots is zero or too large): one age comparator
// walks the slot and age memories one entry per cycle, stopping early at a free slot.
// One item at a time; an item is accepted while a result waits on out_.
module lru_slot_mapper_core #(
  parameter int NUM_ITEMS = lsm_pkg::NUM_ITEMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lsm_pkg::IN_TDATA_W-1:0]   in_tdata,   // item_id
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lsm_pkg::OUT_TDATA_W-1:0]  out_tdata,  // slot, evicted_id
  output logic [lsm_pkg::OUT_TUSER_W-1:0]  out_tuser,  // hit, evict_valid
  input  logic                             cfg_wr_en,
  input  logic [lsm_pkg::NUM_SLOTS_W-1:0]  cfg_wr_data // num_slots
);
  import lsm_pkg::*;

  localparam int IDX_W = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam int CNT_W = $clog2(NUM_ITEMS + 1);
  localparam int EW    = (CNT_W > NUM_SLOTS_W) ? CNT_W : NUM_SLOTS_W;
  localparam int PAD_W = OUT_TDATA_W - 2 * ID_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_SCAN, ST_MAP, ST_UNMAP, ST_RESP
  } state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       clr_r;
  logic [CNT_W-1:0]       iss_r;
  logic                   pend_r;
  logic [IDX_W-1:0]       pend_idx_r;
  logic [IDX_W-1:0]       item_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [IDX_W-1:0]       best_item_r;
  logic [AGE_W-1:0]       best_age_r;
  logic [IDX_W-1:0]       pick_r;
  logic [IDX_W-1:0]       old_r;
  logic                   evict_r;
  logic [AGE_W-1:0]       clock_r;
  logic [NUM_SLOTS_W-1:0] num_slots_r;
  logic [ID_W-1:0]        res_slot_r;
  logic                   res_hit_r;
  logic                   res_ev_r;
  logic [ID_W-1:0]        res_evid_r;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  // memories: {valid, index} maps and slot ages
  logic [IDX_W:0]   i2s_mem [NUM_ITEMS];
  logic [IDX_W:0]   s2i_mem [NUM_ITEMS];
  logic [AGE_W-1:0] age_mem [NUM_ITEMS];
  logic [IDX_W:0]   i2s_rdata_r;
  logic [IDX_W:0]   s2i_rdata_r;
  logic [AGE_W-1:0] age_rdata_r;

  logic             i2s_we, s2i_we, age_we;
  logic [IDX_W-1:0] i2s_waddr, s2i_waddr, age_waddr;
  logic [IDX_W:0]   i2s_wdata, s2i_wdata;
  logic [AGE_W-1:0] age_wdata;
  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] scan_addr;
  logic             in_range;
  logic             accept;
  logic [EW-1:0]    ns_ext;
  logic [CNT_W-1:0] eff_n;
  logic [AGE_W-1:0] clock_inc;

  assign in_idx    = IDX_W'(in_tdata[ID_W-1:0]);
  assign in_range  = 32'(in_tdata[ID_W-1:0]) < 32'(NUM_ITEMS);
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign scan_addr = iss_r[IDX_W-1:0];
  assign clock_inc = clock_r + AGE_W'(1);
  assign ns_ext    = EW'(num_slots_r);
  assign eff_n     = (ns_ext == '0 || ns_ext > EW'(NUM_ITEMS)) ?
                     CNT_W'(NUM_ITEMS) : CNT_W'(ns_ext);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    i2s_we    = (state_r == ST_CLEAR) || (state_r == ST_MAP) || (state_r == ST_UNMAP);
    i2s_waddr = (state_r == ST_CLEAR) ? clr_r[IDX_W-1:0] :
                (state_r == ST_MAP)   ? item_r : old_r;
    i2s_wdata = (state_r == ST_MAP) ? {1'b1, pick_r} : '0;
    s2i_we    = (state_r == ST_CLEAR) || (state_r == ST_MAP);
    s2i_waddr = (state_r == ST_CLEAR) ? clr_r[IDX_W-1:0] : pick_r;
    s2i_wdata = (state_r == ST_MAP) ? {1'b1, item_r} : '0;
    age_we    = (state_r == ST_CLEAR) || (state_r == ST_MAP) ||
                ((state_r == ST_LOOK) && i2s_rdata_r[IDX_W]);
    age_waddr = (state_r == ST_CLEAR) ? clr_r[IDX_W-1:0] :
                (state_r == ST_MAP)   ? pick_r : i2s_rdata_r[IDX_W-1:0];
    age_wdata = (state_r == ST_CLEAR) ? '0 : clock_inc;
  end

  always_ff @(posedge clk) begin
    if (i2s_we) begin
      i2s_mem[i2s_waddr] <= i2s_wdata;
    end
    i2s_rdata_r <= i2s_mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (s2i_we) begin
      s2i_mem[s2i_waddr] <= s2i_wdata;
    end
    s2i_rdata_r <= s2i_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    age_rdata_r <= age_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      iss_r        <= '0;
      pend_r       <= 1'b0;
      clock_r      <= '0;
      num_slots_r  <= NUM_SLOTS_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        num_slots_r <= cfg_wr_data;
      end
      if (out_tvalid_r && out_tready && (state_r != ST_RESP)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + CNT_W'(1);
          if (clr_r == CNT_W'(NUM_ITEMS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            item_r     <= in_idx;
            res_slot_r <= '0;
            res_hit_r  <= 1'b0;
            res_ev_r   <= 1'b0;
            res_evid_r <= '0;
            state_r    <= in_range ? ST_LOOK : ST_RESP;
          end
        end
        ST_LOOK: begin
          if (i2s_rdata_r[IDX_W]) begin
            clock_r    <= clock_inc;
            res_slot_r <= ID_W'(i2s_rdata_r[IDX_W-1:0]);
            res_hit_r  <= 1'b1;
            state_r    <= ST_RESP;
          end else begin
            iss_r   <= '0;
            pend_r  <= 1'b0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (iss_r < eff_n) begin
            iss_r      <= iss_r + CNT_W'(1);
            pend_r     <= 1'b1;
            pend_idx_r <= scan_addr;
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r) begin
            if (!s2i_rdata_r[IDX_W]) begin
              pick_r  <= pend_idx_r;
              evict_r <= 1'b0;
              state_r <= ST_MAP;
            end else if (pend_idx_r == '0 || age_rdata_r < best_age_r) begin
              best_idx_r  <= pend_idx_r;
              best_age_r  <= age_rdata_r;
              best_item_r <= s2i_rdata_r[IDX_W-1:0];
            end
          end else if (iss_r >= eff_n) begin
            pick_r  <= best_idx_r;
            old_r   <= best_item_r;
            evict_r <= 1'b1;
            state_r <= ST_MAP;
          end
        end
        ST_MAP: begin
          clock_r    <= clock_inc;
          res_slot_r <= ID_W'(pick_r);
          res_ev_r   <= evict_r;
          res_evid_r <= evict_r ? ID_W'(old_r) : '0;
          state_r    <= evict_r ? ST_UNMAP : ST_RESP;
        end
        ST_UNMAP: begin
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {{PAD_W{1'b0}}, res_evid_r, res_slot_r};
            out_tuser_r  <= {res_ev_r, res_hit_r};
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/lsm_checker.sv
// Port-level checker for the LRU slot mapper, bound to lru_slot_mapper_core
`include "lru_slot_mapper_core_defines.svh"

module lsm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lsm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [lsm_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import lsm_pkg::*;

  `LSM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out item dropped while stalled")
  `LSM_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser), "out item changed while stalled")
  `LSM_ASSERT_SAME(a_hit_no_evict, out_tvalid && out_tuser[0], !out_tuser[1], "hit reported with eviction")
  `LSM_ASSERT_SAME(a_evid_zero, out_tvalid && !out_tuser[1], out_tdata[2*ID_W-1:ID_W] == '0, "evicted id set without eviction")
  `LSM_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken while busy")

endmodule

bind lru_slot_mapper_core lsm_checker u_lsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
